>>> rtl/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared constants for the counting semaphore with a FIFO wait queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned EVENT_W = 3;

  localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNAL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd3;

  localparam logic [EVENT_W-1:0] EV_GRANTED    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_QUEUED     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_WOKEN      = 3'd2;
  localparam logic [EVENT_W-1:0] EV_REMOVED    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_NOT_FOUND  = 3'd4;
  localparam logic [EVENT_W-1:0] EV_NONE_WOKEN = 3'd5;
  localparam logic [EVENT_W-1:0] EV_FULL       = 3'd6;

endpackage

>>> rtl/csfw_ram.sv
// ----------------------------------------------------------------------------
// csfw_ram
// Wait queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csfw_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a circular FIFO queue of waiting process ids.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser = kind (wait, signal, cancel, destroy),
// tdata = process id. Output channel m_axis: tuser = event code,
// tdata = process id, tlast marks the final result of an input item.
// One item is worked on at a time; s_axis_tready is high only while idle.
// The queue sits in a RAM with one read port, addressed relative to a head
// pointer; each queue read has a request state and a state that uses the data:
//   wait            one state, one result
//   signal/destroy  a request and a data state per waiter woken (a none-woken result when none is)
//   cancel          a search (request, check) per entry up to the match, then a
//                   shift (request, write) per entry moved up, then the result
// The output register lets the next item be taken while the final result
// waits; a stalled m_axis_tready holds the sequencer before each result.
// Reset (rst, synchronous) empties the queue and clears the count; the RAM
// keeps its contents and needs no clearing pass. Destroy, like reset, ends
// with the queue empty and the count clear.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters
  import csfw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = ID_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((ID_BITS+7)/8)*8-1:0]    s_axis_tdata,   // process_id
  input  logic [KIND_W-1:0]               s_axis_tuser,   // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [((ID_BITS+7)/8)*8-1:0]    m_axis_tdata,   // process_id_res
  output logic [EVENT_W-1:0]              m_axis_tuser,   // event_res
  output logic                            m_axis_tlast
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW    = ((ID_BITS + 7) / 8) * 8;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_WAIT      = 4'd1;
  localparam logic [3:0] ST_POP_REQ   = 4'd2;
  localparam logic [3:0] ST_POP_DATA  = 4'd3;
  localparam logic [3:0] ST_SRCH_REQ  = 4'd4;
  localparam logic [3:0] ST_SRCH_CHK  = 4'd5;
  localparam logic [3:0] ST_SHIFT_REQ = 4'd6;
  localparam logic [3:0] ST_SHIFT_WR  = 4'd7;
  localparam logic [3:0] ST_CANCEL    = 4'd8;

  logic [3:0]            state;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] budget;
  logic [CNT_W-1:0]      total;
  logic [CNT_W-1:0]      off;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      hole;
  logic [PTR_W-1:0]      rd_addr;
  logic [ID_BITS-1:0]    pid;
  logic                  drain;
  logic                  found;

  logic [CNT_W-1:0]      off_sel;
  logic [CNT_W:0]        addr_sum;
  logic [PTR_W-1:0]      qaddr;
  logic [PTR_W-1:0]      head_inc;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  out_free;
  logic                  q_full;
  logic                  pop_last;

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [ID_BITS-1:0]    ram_wdata;
  logic                  ram_re;
  logic [PTR_W-1:0]      ram_raddr;
  logic [ID_BITS-1:0]    ram_rdata;

  // queue offset to RAM address, wrapping round the circular buffer
  assign off_sel  = (state == ST_WAIT) ? total : off;
  assign addr_sum = (CNT_W+1)'(head) + (CNT_W+1)'(off_sel);
  assign qaddr    = (addr_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? PTR_W'(addr_sum - (CNT_W+1)'(QUEUE_DEPTH))
                    : PTR_W'(addr_sum);
  assign head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

  assign count_inc = (&count) ? count : count + 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign q_full    = (total == CNT_W'(QUEUE_DEPTH));
  assign pop_last  = (total == CNT_W'(1)) || (!drain && budget == COUNT_BITS'(1));

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = qaddr;
    ram_wdata = pid;
    ram_re    = 1'b0;
    ram_raddr = qaddr;
    case (state)
      ST_WAIT: begin
        ram_we = out_free && count == '0 && !q_full;
      end
      ST_POP_REQ: begin
        ram_re    = (drain || budget != '0) && total != '0;
        ram_raddr = head;
      end
      ST_SRCH_REQ, ST_SHIFT_REQ: begin
        ram_re = (off != total);
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hole;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  csfw_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_addr <= ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      total         <= '0;
      head          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            pid   <= s_axis_tdata[ID_BITS-1:0];
            off   <= '0;
            found <= 1'b0;
            drain <= (s_axis_tuser == KIND_DESTROY);
            case (s_axis_tuser)
              KIND_WAIT: begin
                state <= ST_WAIT;
              end
              KIND_SIGNAL: begin
                count  <= count_inc;
                budget <= count_inc;
                state  <= ST_POP_REQ;
              end
              KIND_CANCEL: begin
                state <= ST_SRCH_REQ;
              end
              default: begin
                state <= ST_POP_REQ;
              end
            endcase
          end
        end

        ST_WAIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= DW'(pid);
            m_axis_tlast  <= 1'b1;
            if (count != '0) begin
              count        <= count - 1'b1;
              m_axis_tuser <= EV_GRANTED;
            end else if (!q_full) begin
              total        <= total + 1'b1;
              m_axis_tuser <= EV_QUEUED;
            end else begin
              m_axis_tuser <= EV_FULL;
            end
            state <= ST_IDLE;
          end
        end

        ST_POP_REQ: begin
          if (ram_re) begin
            state <= ST_POP_DATA;
          end else if (out_free) begin
            // nobody to wake
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tuser  <= EV_NONE_WOKEN;
            m_axis_tlast  <= 1'b1;
            if (drain) begin
              count <= '0;
              head  <= '0;
            end
            state <= ST_IDLE;
          end
        end

        ST_POP_DATA: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= DW'(ram_rdata);
            m_axis_tuser  <= EV_WOKEN;
            m_axis_tlast  <= pop_last;
            head          <= head_inc;
            total         <= total - 1'b1;
            budget        <= budget - 1'b1;
            if (!drain && count != '0) begin
              count <= count - 1'b1;
            end
            if (pop_last) begin
              state <= ST_IDLE;
              if (drain) begin
                count <= '0;
                total <= '0;
                head  <= '0;
              end
            end else begin
              state <= ST_POP_REQ;
            end
          end
        end

        ST_SRCH_REQ: begin
          state <= (off == total) ? ST_CANCEL : ST_SRCH_CHK;
        end

        ST_SRCH_CHK: begin
          off <= off + 1'b1;
          if (ram_rdata == pid) begin
            found <= 1'b1;
            hole  <= rd_addr;
            state <= ST_SHIFT_REQ;
          end else begin
            state <= ST_SRCH_REQ;
          end
        end

        ST_SHIFT_REQ: begin
          state <= (off == total) ? ST_CANCEL : ST_SHIFT_WR;
        end

        ST_SHIFT_WR: begin
          hole  <= rd_addr;
          off   <= off + 1'b1;
          state <= ST_SHIFT_REQ;
        end

        ST_CANCEL: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= DW'(pid);
            m_axis_tuser  <= found ? EV_REMOVED : EV_NOT_FOUND;
            m_axis_tlast  <= 1'b1;
            if (found) begin
              total <= total - 1'b1;
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/csfw_check.sv
// ----------------------------------------------------------------------------
// csfw_check
// Port-level checks for the semaphore block, bound to the top level.
// ----------------------------------------------------------------------------
module csfw_check
  import csfw_pkg::*;
#(
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [((ID_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic [EVENT_W-1:0]           m_axis_tuser,
  input logic                         m_axis_tlast
);

  // no output item survives reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output item valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  // single-result answers always close their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_GRANTED || m_axis_tuser == EV_QUEUED ||
      m_axis_tuser == EV_REMOVED || m_axis_tuser == EV_NOT_FOUND ||
      m_axis_tuser == EV_FULL || m_axis_tuser == EV_NONE_WOKEN) |-> m_axis_tlast)
    else $error("single-result event without tlast");

  a_none_woken_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == EV_NONE_WOKEN |-> m_axis_tdata == '0)
    else $error("none-woken event carries an id");

  // no new item is taken while a wake-up run is still open
  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == EV_WOKEN && !m_axis_tlast
      |-> !(s_axis_tvalid && s_axis_tready))
    else $error("item accepted inside a wake-up run");

endmodule

bind counting_semaphore_fifo_waiters csfw_check #(
  .ID_BITS (ID_BITS)
) u_csfw_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/counting_semaphore_fifo_waiters_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_tb
// Self-checking bench for the counting semaphore with its FIFO of waiters.
// A queue-fed driver offers wait, signal, cancel and destroy items with
// random gaps. On each accepted item a local model of the count and the
// waiter list predicts the event items. A monitor checks every output item
// against the oldest prediction. Phases: directed corner cases, a run of
// signals that builds up the count, and random bursts. One long receiver
// hold-off makes the block back up and stall its input.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_tb;
  import csfw_pkg::*;

  localparam int ID_W       = ID_BITS_DEF;
  localparam int DATA_W     = ((ID_BITS_DEF + 7) / 8) * 8;
  localparam int COUNT_W    = COUNT_BITS_DEF;
  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int RAND_ITEMS = 430;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_LEN   = 4 * DEPTH + 16;
  localparam int CYCLE_CAP  = 4000000;
  localparam int REPORT_CAP = 100;
  localparam logic [COUNT_W-1:0] UNITS_MAX = '1;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   pid;
    int unsigned       gap;
  } sem_req_t;

  typedef struct {
    logic [EVENT_W-1:0] ev;
    logic [ID_W-1:0]    pid;
    logic               last;
  } sem_event_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // process_id
  logic [KIND_W-1:0] s_axis_tuser = '0;   // kind
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // process_id_res
  logic [EVENT_W-1:0] m_axis_tuser;       // event_res
  logic              m_axis_tlast;

  sem_req_t   pending_reqs[$];
  sem_event_t events_due[$];
  sem_event_t head_ev;

  logic [COUNT_W-1:0] units;
  logic [ID_W-1:0]    waiters[DEPTH];
  logic [4:0]         waiter_cnt;

  int unsigned src_gap_left;
  int unsigned sink_stall_left;
  int unsigned items_taken;
  int unsigned hold_mark = 32'hffff_ffff;
  int unsigned hold_left;
  bit          hold_done;
  bit          sink_calm;
  int unsigned failures;
  int unsigned cycles;

  counting_semaphore_fifo_waiters i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Semaphore state update; appends the event items one request causes.
  task automatic semaphore_step(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] pid);
    sem_event_t  burst[$];
    logic [COUNT_W-1:0] budget;
    logic [ID_W-1:0] w;
    bit hit;
    int i;
    int j;
    case (kind)
      KIND_WAIT: begin
        if (units != 0) begin
          units = units - 1'b1;
          burst.push_back('{EV_GRANTED, pid, 1'b0});
        end else if (waiter_cnt < DEPTH) begin
          waiters[waiter_cnt] = pid;
          waiter_cnt = waiter_cnt + 1'b1;
          burst.push_back('{EV_QUEUED, pid, 1'b0});
        end else begin
          burst.push_back('{EV_FULL, pid, 1'b0});
        end
      end
      KIND_SIGNAL: begin
        if (units != UNITS_MAX) units = units + 1'b1;
        budget = units;
        while (budget != 0 && waiter_cnt != 0) begin
          w = waiters[0];
          for (i = 1; i < waiter_cnt; i++) waiters[i-1] = waiters[i];
          waiter_cnt = waiter_cnt - 1'b1;
          if (units != 0) units = units - 1'b1;
          burst.push_back('{EV_WOKEN, w, 1'b0});
          budget = budget - 1'b1;
        end
        if (burst.size() == 0) burst.push_back('{EV_NONE_WOKEN, '0, 1'b0});
      end
      KIND_CANCEL: begin
        hit = 1'b0;
        for (i = 0; i < waiter_cnt && !hit; i++) begin
          if (waiters[i] == pid) begin
            hit = 1'b1;
            for (j = i + 1; j < waiter_cnt; j++) waiters[j-1] = waiters[j];
          end
        end
        if (hit) waiter_cnt = waiter_cnt - 1'b1;
        burst.push_back('{hit ? EV_REMOVED : EV_NOT_FOUND, pid, 1'b0});
      end
      default: begin
        for (i = 0; i < waiter_cnt; i++) burst.push_back('{EV_WOKEN, waiters[i], 1'b0});
        if (burst.size() == 0) burst.push_back('{EV_NONE_WOKEN, '0, 1'b0});
        units = '0;
        waiter_cnt = '0;
      end
    endcase
    burst[burst.size()-1].last = 1'b1;
    foreach (burst[k]) events_due.push_back(burst[k]);
  endtask

  task automatic queue_req(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] pid,
                           input int unsigned gap);
    pending_reqs.push_back('{kind, pid, gap});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_axis_tvalid || events_due.size() != 0);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap_left = 0;
      units = '0;
      waiter_cnt = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        semaphore_step(s_axis_tuser, s_axis_tdata[ID_W-1:0]);
        items_taken <= items_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap_left != 0) begin
          src_gap_left = src_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0 && pending_reqs[0].gap != 0) begin
          src_gap_left = pending_reqs[0].gap - 1;
          pending_reqs[0].gap = 0;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          s_axis_tuser  <= pending_reqs[0].kind;
          s_axis_tdata  <= DATA_W'(pending_reqs[0].pid);
          s_axis_tvalid <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver long hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= hold_mark) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall_left = 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall_left != 0) begin
      sink_stall_left = sink_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_stall_left = sink_calm ? 0 : pick_gap();
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (events_due.size() == 0) begin
        failures++;
        if (failures < REPORT_CAP)
          $error("unexpected item: event_res %0d process_id_res 0x%0h last %0b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        head_ev = events_due.pop_front();
        if (m_axis_tuser !== head_ev.ev) begin
          failures++;
          if (failures < REPORT_CAP)
            $error("event_res: expected %0d, got %0d", head_ev.ev, m_axis_tuser);
        end
        if (m_axis_tdata[ID_W-1:0] !== head_ev.pid) begin
          failures++;
          if (failures < REPORT_CAP)
            $error("process_id_res: expected 0x%0h, got 0x%0h", head_ev.pid,
                   m_axis_tdata[ID_W-1:0]);
        end
        if (m_axis_tlast !== head_ev.last) begin
          failures++;
          if (failures < REPORT_CAP)
            $error("last: expected %0b, got %0b", head_ev.last, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0] pool[6];
    int unsigned made;
    int unsigned n;
    int unsigned r;
    bit calm;
    logic [ID_W-1:0] fill_ids[16];

    fill_ids = '{8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h00,
                 8'h88, 8'h99, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'hFF};

    // directed corners: empty signal, grant, full queue with a duplicate id,
    // overflow, cancels hit and miss, wake, drain, empty drain
    queue_req(KIND_SIGNAL, 8'h00, pick_gap());
    queue_req(KIND_WAIT, 8'hA5, pick_gap());
    foreach (fill_ids[k]) queue_req(KIND_WAIT, fill_ids[k], pick_gap());
    queue_req(KIND_WAIT, 8'h5A, pick_gap());
    queue_req(KIND_CANCEL, 8'h00, pick_gap());
    queue_req(KIND_CANCEL, 8'h77, pick_gap());
    queue_req(KIND_SIGNAL, 8'hFF, pick_gap());
    queue_req(KIND_DESTROY, 8'h3C, pick_gap());
    queue_req(KIND_CANCEL, 8'h00, pick_gap());
    queue_req(KIND_DESTROY, 8'hFF, pick_gap());

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // count build-up: a run of signals, then waits that take units
    sink_calm = 1'b1;
    for (int k = 0; k < 8; k++) queue_req(KIND_SIGNAL, ID_W'(k), 0);
    repeat (3) queue_req(KIND_WAIT, 8'h3C, 0);
    queue_req(KIND_SIGNAL, 8'h00, 0);
    queue_req(KIND_DESTROY, 8'h00, 0);
    wait_idle();
    sink_calm = 1'b0;

    // random bursts over a small id pool so cancels and duplicates hit
    foreach (pool[k]) pool[k] = ID_W'($urandom);
    hold_mark = items_taken + 30;
    made = 0;
    while (made < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) pool[$urandom_range(0, 5)] = ID_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        n = $urandom_range(1, 20);
        repeat (n) queue_req(KIND_WAIT, ($urandom_range(0, 9) < 7) ?
                             pool[$urandom_range(0, 5)] : ID_W'($urandom),
                             calm ? 0 : pick_gap());
      end else if (r < 60) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_req(KIND_CANCEL, ($urandom_range(0, 3) != 0) ?
                             pool[$urandom_range(0, 5)] : ID_W'($urandom),
                             calm ? 0 : pick_gap());
      end else if (r < 85) begin
        n = $urandom_range(1, 3);
        repeat (n) queue_req(KIND_SIGNAL, ID_W'($urandom), calm ? 0 : pick_gap());
      end else if (r < 90) begin
        n = 1;
        queue_req(KIND_DESTROY, ID_W'($urandom), calm ? 0 : pick_gap());
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) queue_req(KIND_W'($urandom), ID_W'($urandom), calm ? 0 : pick_gap());
      end
      made += n;
    end
    wait_idle();
    repeat (TAIL_LEN) @(negedge clk);

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
